// ===== rtl/gks_pkg.sv =====
// Shared types, constants and elaboration-time table functions for the
// Gaussian kernel sum block. No dependencies.
package gks_pkg;

  localparam int EXP_TABLE_DEPTH_DEFAULT = 64;
  localparam int QUEUE_DEPTH = 4;
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_EXPONENT_SCALE   = 1'b0,
    REG_PEAK_COEFFICIENT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
    logic signed [15:0] center_z;
    logic               last_center;
  } in_item_t;

  typedef struct packed {
    logic [31:0] response;
    logic        saturated;
  } out_item_t;

  typedef struct packed {
    logic [31:0] sq_x;
    logic [31:0] sq_y;
    logic [31:0] sq_z;
    logic        last;
  } sq_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Truncating Q0.32 multiply; operands stay below 2^32.
  function automatic logic [63:0] mul_q32(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] p;
    p = a * b;
    return p >> 32;
  endfunction

  function automatic logic [63:0] pow_q32(input logic [63:0] x, input int unsigned n);
    logic [63:0] acc;
    logic [63:0] base;
    logic        have;
    int unsigned m;
    acc  = '0;
    base = x;
    have = 1'b0;
    m    = n;
    for (int k = 0; k < 32; k++) begin
      if (m != 0) begin
        if (m[0]) begin
          acc  = have ? mul_q32(acc, base) : base;
          have = 1'b1;
        end
        m = m >> 1;
        if (m != 0) begin
          base = mul_q32(base, base);
        end
      end
    end
    return acc;
  endfunction

  // Largest Q0.32 root whose depth-th power is at most one half.
  function automatic logic [63:0] exp_root(input int unsigned depth);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    lo = '0;
    hi = 64'hFFFF_FFFF;
    for (int k = 0; k < 34; k++) begin
      if (lo < hi) begin
        mid = lo + ((hi - lo + 64'd1) >> 1);
        if (pow_q32(mid, depth) <= 64'h8000_0000) begin
          lo = mid;
        end else begin
          hi = mid - 64'd1;
        end
      end
    end
    return lo;
  endfunction

  function automatic logic [16:0] exp_entry(input logic [63:0] root, input int unsigned i);
    logic [63:0] p;
    logic [63:0] r;
    p = root;
    if (i == 0) begin
      return 17'h10000;
    end
    for (int unsigned k = 1; k < i; k++) begin
      p = mul_q32(p, root);
    end
    r = (p + 64'h8000) >> 16;
    return r[16:0];
  endfunction

endpackage

// ===== rtl/gks_front.sv =====
// Input side: takes transfers while the queue has room and forms the
// per-axis squared distances. Depends on gks_pkg.
module gks_front (
  input  logic                  in_valid,
  output logic                  in_ready,
  input  gks_pkg::in_item_t     in_item,
  input  gks_pkg::queue_status_t q_status,
  output logic                  push,
  output gks_pkg::sq_item_t     push_item
);
  import gks_pkg::*;

  function automatic logic [31:0] sq_diff(input logic signed [15:0] a,
                                          input logic signed [15:0] b);
    logic signed [16:0] d;
    logic [15:0]        m;
    d = {a[15], a} - {b[15], b};
    m = d[16] ? 16'(-d) : 16'(d);
    return m * m;
  endfunction

  assign in_ready = !q_status.full;
  assign push     = in_valid && in_ready;

  always_comb begin
    push_item.sq_x = sq_diff(in_item.point_x, in_item.center_x);
    push_item.sq_y = sq_diff(in_item.point_y, in_item.center_y);
    push_item.sq_z = sq_diff(in_item.point_z, in_item.center_z);
    push_item.last = in_item.last_center;
  end

endmodule

// ===== rtl/gks_queue.sv =====
// Short FIFO between the front and the back pipeline.
// Depends on gks_pkg.
module gks_queue #(
  parameter int DEPTH = gks_pkg::QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  gks_pkg::sq_item_t      push_item,
  input  logic                   pop,
  output gks_pkg::sq_item_t      pop_item,
  output gks_pkg::queue_status_t q_status
);
  import gks_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  sq_item_t         mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign pop_item       = mem[rd_ptr];
  assign q_status.full  = (count == FULL_CNT);
  assign q_status.empty = (count == '0);

endmodule

// ===== rtl/gks_back.sv =====
// Back pipeline: distance scaling, exp2 table lookup, peak scaling and the
// saturating accumulator with the result register. Depends on gks_pkg.
module gks_back #(
  parameter int EXP_TABLE_DEPTH = gks_pkg::EXP_TABLE_DEPTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  gks_pkg::queue_status_t q_status,
  input  gks_pkg::sq_item_t      pop_item,
  output logic                   pop,
  input  logic [15:0]            exponent_scale,
  input  logic [15:0]            peak_coefficient,
  output logic                   out_valid,
  input  logic                   out_ready,
  output gks_pkg::out_item_t     out_item
);
  import gks_pkg::*;

  localparam int IDX_W = $clog2(EXP_TABLE_DEPTH);
  localparam logic [63:0] EXP_ROOT = exp_root(EXP_TABLE_DEPTH);
  localparam logic [IDX_W:0] DEPTH_C = (IDX_W + 1)'(EXP_TABLE_DEPTH);

  logic [16:0] exp_rom [EXP_TABLE_DEPTH];
  for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_rom
    assign exp_rom[g] = exp_entry(EXP_ROOT, g);
  end

  logic adv;
  logic [6:1] vld;
  logic [6:1] lst;

  logic [33:0]       d2;
  logic [33:0]       t;
  logic [50:0]       u;
  logic [IDX_W-1:0]  idx;
  logic [4:0]        shift4;
  logic              zero4;
  logic [16:0]       entry;
  logic [4:0]        shift5;
  logic              zero5;
  logic [32:0]       prod;
  logic [5:0]        shamt;
  logic              zero6;

  logic [31:0] running_sum;
  logic        clip_seen;

  logic [49:0]         scaled;
  logic [50:0]         u_full;
  logic [IDX_W+32:0]   frac_scaled;
  logic [32:0]         term;
  logic [32:0]         sum;
  logic [31:0]         sum_sat;
  logic                clip_next;

  assign adv = !out_valid || out_ready;
  assign pop = adv && !q_status.empty;

  always_comb begin
    scaled      = d2 * exponent_scale;
    u_full      = t * LOG2E_Q16;
    frac_scaled = u[31:0] * DEPTH_C;
    term        = zero6 ? '0 : (prod >> shamt);
    sum         = {1'b0, running_sum} + term;
    sum_sat     = sum[32] ? '1 : sum[31:0];
    clip_next   = clip_seen | sum[32];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[5:1], !q_status.empty};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lst    <= {lst[5:1], pop_item.last};
      d2     <= 34'(pop_item.sq_x) + 34'(pop_item.sq_y) + 34'(pop_item.sq_z);
      t      <= scaled[49:16];
      u      <= u_full;
      idx    <= frac_scaled[32 +: IDX_W];
      shift4 <= u[36:32];
      zero4  <= |u[50:37];
      entry  <= exp_rom[idx];
      shift5 <= shift4;
      zero5  <= zero4;
      prod   <= entry * peak_coefficient;
      shamt  <= 6'd8 + 6'(shift5);
      zero6  <= zero5;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      clip_seen   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (adv && vld[6]) begin
        if (lst[6]) begin
          running_sum <= '0;
          clip_seen   <= 1'b0;
          out_valid   <= 1'b1;
        end else begin
          running_sum <= sum_sat;
          clip_seen   <= clip_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vld[6] && lst[6]) begin
      out_item.response  <= sum_sat;
      out_item.saturated <= clip_next;
    end
  end

endmodule

// ===== rtl/gaussian_kernel_sum.sv =====
// Gaussian kernel sum top level: configuration registers, front, queue, back.
// Throughput: one center per cycle while no result is held; set by the accumulator feedback loop.
// A held result stalls the back pipeline; the 4-entry queue absorbs input.
// Reset (synchronous): registers, sum and flags clear; queue empties; no sweep.
module gaussian_kernel_sum #(
  parameter int EXP_TABLE_DEPTH = gks_pkg::EXP_TABLE_DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  gks_pkg::in_item_t               in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output gks_pkg::out_item_t              out_item,
  input  logic                            cfg_wr_en,
  input  logic [gks_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [gks_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import gks_pkg::*;

  logic [15:0]   exponent_scale;
  logic [15:0]   peak_coefficient;
  queue_status_t q_status;
  logic          push;
  logic          pop;
  sq_item_t      push_item;
  sq_item_t      pop_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      exponent_scale   <= '0;
      peak_coefficient <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_EXPONENT_SCALE:   exponent_scale   <= cfg_data;
        REG_PEAK_COEFFICIENT: peak_coefficient <= cfg_data;
        default: ;
      endcase
    end
  end

  gks_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .q_status  (q_status),
    .push      (push),
    .push_item (push_item)
  );

  gks_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_status  (q_status)
  );

  gks_back #(
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .q_status         (q_status),
    .pop_item         (pop_item),
    .pop              (pop),
    .exponent_scale   (exponent_scale),
    .peak_coefficient (peak_coefficient),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_item         (out_item)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("pop from empty queue");

  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !q_status.empty)
    else $error("queue empty after transfer");

  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    cfg_wr_en && cfg_index == REG_EXPONENT_SCALE |=> exponent_scale == $past(cfg_data))
    else $error("exponent_scale write lost");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule
